[src/kscd_pkg.sv]
package kscd_pkg;

	localparam int CodeW  = 8;
	localparam int CharW  = 7;
	localparam int KindW  = 5;
	localparam int CfgW   = 8;
	localparam int NumTgl = 4;

	// register indexes on the config port
	typedef enum logic [0:0] {
		CFG_REPEAT_DELAY    = 1'b0,
		CFG_REPEAT_INTERVAL = 1'b1
	} cfg_index_t;

	localparam logic [CfgW-1:0] RESET_REPEAT_DELAY    = 8'd30;
	localparam logic [CfgW-1:0] RESET_REPEAT_INTERVAL = 8'd4;

	// set 2 codes with special handling
	localparam logic [CodeW-1:0] CODE_LCTRL  = 8'h14;
	localparam logic [CodeW-1:0] CODE_LSHIFT = 8'h12;
	localparam logic [CodeW-1:0] CODE_RSHIFT = 8'h59;

	// toggle bits: 0 caps, 1 num, 2 insert, 3 scroll
	localparam int TGL_CAPS = 0;
	localparam int TGL_NUM  = 1;
	localparam int TGL_INS  = 2;
	localparam int TGL_SCR  = 3;

	localparam logic [CodeW-1:0] TOGGLE_CODES [NumTgl] = '{8'h58, 8'h77, 8'd129, 8'h7E};

	typedef enum logic [KindW-1:0] {
		EV_NONE   = 5'd0,
		EV_ENTER  = 5'd1,
		EV_TAB    = 5'd2,
		EV_BKSP   = 5'd3,
		EV_ESC    = 5'd4,
		EV_LEFT   = 5'd5,
		EV_RIGHT  = 5'd6,
		EV_UP     = 5'd7,
		EV_DOWN   = 5'd8,
		EV_CLEFT  = 5'd9,
		EV_CRIGHT = 5'd10,
		EV_CUP    = 5'd11,
		EV_CDOWN  = 5'd12,
		EV_DEL    = 5'd13,
		EV_CHAR   = 5'd14,
		EV_HOME   = 5'd15,
		EV_END    = 5'd16,
		EV_PGUP   = 5'd17,
		EV_PGDN   = 5'd18,
		EV_F2     = 5'd19,
		EV_F3     = 5'd20,
		EV_F5     = 5'd21,
		EV_F6     = 5'd22,
		EV_F8     = 5'd23,
		EV_F9     = 5'd24,
		EV_F10    = 5'd25,
		EV_F11    = 5'd26,
		EV_F12    = 5'd27,
		EV_CLEAR  = 5'd28
	} event_kind_t;

	// modifier and lock state seen by the decoder
	typedef struct packed {
		logic ctrl;
		logic shift;
		logic caps;
		logic num;
	} kscd_mods_t;

endpackage

[src/keyboard_scancode_decoder.sv]
// Channel   Handshake                 Payload
// in        in_valid / in_stall       keyboard_present, make_flag, break_flag, scan_code
// out       out_valid / out_stall     event_kind, character, caps_lock_on, num_lock_on,
//                                     insert_on, scroll_lock_on
// cfg       cfg_write_en              cfg_index, cfg_data (no stall, no read-back)
//
// One report per cycle sustained while out_stall does not hold the result register.
// Stage 1 holds the report; modifier, lock and repeat state update and the
// table decode happen between it and the result register.
// Reset clears the valid flags and decoder state, toggles off, delay 30 and interval 4.
// in_stall rises only when stage 1 is full and the result register is held.
module keyboard_scancode_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          keyboard_present,
	input  logic                          make_flag,
	input  logic                          break_flag,
	input  logic [kscd_pkg::CodeW-1:0]    scan_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kscd_pkg::KindW-1:0]    event_kind,
	output logic [kscd_pkg::CharW-1:0]    character,
	output logic                          caps_lock_on,
	output logic                          num_lock_on,
	output logic                          insert_on,
	output logic                          scroll_lock_on,
	input  logic                          cfg_write_en,
	input  logic [0:0]                    cfg_index,
	input  logic [kscd_pkg::CfgW-1:0]     cfg_data
);
	import kscd_pkg::*;

	// config registers
	logic [CfgW-1:0] repeat_delay_q;
	logic [CfgW-1:0] repeat_interval_q;

	// stage 1: captured report
	logic             valid_s1;
	logic             present_s1;
	logic             make_s1;
	logic             break_s1;
	logic [CodeW-1:0] code_s1;

	// decoder state
	logic [CodeW-1:0]  prev_code_q;
	logic [CfgW-1:0]   countdown_q;
	logic              ctrl_q;
	logic              shift_q;
	logic [NumTgl-1:0] latch_q;
	logic [NumTgl-1:0] toggles_q;

	// result register
	logic              out_valid_q;
	event_kind_t       kind_q;
	logic [CharW-1:0]  char_q;
	logic [NumTgl-1:0] out_tgl_q;

	// next-state values
	logic              ctrl_n;
	logic              shift_n;
	logic [NumTgl-1:0] latch_n;
	logic [NumTgl-1:0] toggles_n;
	logic [CodeW-1:0]  prev_n;
	logic [CfgW-1:0]   countdown_n;
	logic              emit;
	kscd_mods_t        mods;
	event_kind_t       dec_kind;
	logic [CharW-1:0]  dec_char;

	logic advance;   // result register free to take stage 1
	logic fire;      // stage 1 transaction retires this cycle

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// modifiers and locks; make applies before break within one report
	always_comb begin
		ctrl_n    = ctrl_q;
		shift_n   = shift_q;
		latch_n   = latch_q;
		toggles_n = toggles_q;
		if (!present_s1) begin
			ctrl_n = 1'b0;
		end else begin
			if (code_s1 == CODE_LCTRL) begin
				ctrl_n = break_s1 ? 1'b0 : (make_s1 ? 1'b1 : ctrl_q);
			end
			if (code_s1 == CODE_LSHIFT || code_s1 == CODE_RSHIFT) begin
				shift_n = break_s1 ? 1'b0 : (make_s1 ? 1'b1 : shift_q);
			end
			for (int i = 0; i < NumTgl; i++) begin
				if (code_s1 == TOGGLE_CODES[i]) begin
					if (make_s1 && !latch_q[i]) begin
						toggles_n[i] = ~toggles_q[i];
						latch_n[i]   = 1'b1;
					end
					if (break_s1) begin
						latch_n[i] = 1'b0;
					end
				end
			end
		end
	end

	// typematic repeat: fresh key emits at once, then delay, then interval.
	// A countdown loaded with zero behaves like one.
	always_comb begin
		prev_n      = prev_code_q;
		countdown_n = countdown_q;
		emit        = 1'b0;
		if (!present_s1 || !make_s1 || code_s1 == '0) begin
			prev_n = '0;
		end else if (code_s1 != prev_code_q) begin
			prev_n      = code_s1;
			countdown_n = repeat_delay_q;
			emit        = 1'b1;
		end else if (countdown_q <= 8'd1) begin
			countdown_n = repeat_interval_q;
			emit        = 1'b1;
		end else begin
			countdown_n = countdown_q - 8'd1;
		end
	end

	// decoder sees the modifier and lock state after this report
	assign mods.ctrl  = ctrl_n;
	assign mods.shift = shift_n;
	assign mods.caps  = toggles_n[TGL_CAPS];
	assign mods.num   = toggles_n[TGL_NUM];

	kscd_decode u_decode (
		.code (code_s1),
		.mods (mods),
		.kind (dec_kind),
		.ch   (dec_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q    <= RESET_REPEAT_DELAY;
			repeat_interval_q <= RESET_REPEAT_INTERVAL;
		end else if (cfg_write_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_REPEAT_DELAY:    repeat_delay_q    <= cfg_data;
				CFG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			present_s1 <= keyboard_present;
			make_s1    <= make_flag;
			break_s1   <= break_flag;
			code_s1    <= scan_code;
		end
	end

	// state update on each retiring report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q <= '0;
			countdown_q <= '0;
			ctrl_q      <= 1'b0;
			shift_q     <= 1'b0;
			latch_q     <= '0;
			toggles_q   <= '0;
		end else if (fire) begin
			prev_code_q <= prev_n;
			countdown_q <= countdown_n;
			ctrl_q      <= ctrl_n;
			shift_q     <= shift_n;
			latch_q     <= latch_n;
			toggles_q   <= toggles_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q    <= emit ? dec_kind : EV_NONE;
			char_q    <= emit ? dec_char : '0;
			out_tgl_q <= toggles_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = kind_q;
	assign character      = char_q;
	assign caps_lock_on   = out_tgl_q[TGL_CAPS];
	assign num_lock_on    = out_tgl_q[TGL_NUM];
	assign insert_on      = out_tgl_q[TGL_INS];
	assign scroll_lock_on = out_tgl_q[TGL_SCR];

endmodule

[src/kscd_decode.sv]
module kscd_decode (
	input  logic [kscd_pkg::CodeW-1:0] code,
	input  kscd_pkg::kscd_mods_t       mods,
	output kscd_pkg::event_kind_t      kind,
	output logic [kscd_pkg::CharW-1:0] ch
);
	import kscd_pkg::*;

	// US base map, ASCII, 0 = no character
	function automatic logic [CharW-1:0] base_map(input logic [CharW-1:0] idx);
		logic [CharW-1:0] c;
		case (idx)
			7'd14:  c = 7'h60;
			7'd21:  c = 7'h71;
			7'd22:  c = 7'h31;
			7'd26:  c = 7'h7a;
			7'd27:  c = 7'h73;
			7'd28:  c = 7'h61;
			7'd29:  c = 7'h77;
			7'd30:  c = 7'h32;
			7'd33:  c = 7'h63;
			7'd34:  c = 7'h78;
			7'd35:  c = 7'h64;
			7'd36:  c = 7'h65;
			7'd37:  c = 7'h34;
			7'd38:  c = 7'h33;
			7'd41:  c = 7'h20;
			7'd42:  c = 7'h76;
			7'd43:  c = 7'h66;
			7'd44:  c = 7'h74;
			7'd45:  c = 7'h72;
			7'd46:  c = 7'h35;
			7'd49:  c = 7'h6e;
			7'd50:  c = 7'h62;
			7'd51:  c = 7'h68;
			7'd52:  c = 7'h67;
			7'd53:  c = 7'h79;
			7'd54:  c = 7'h36;
			7'd58:  c = 7'h6d;
			7'd59:  c = 7'h6a;
			7'd60:  c = 7'h75;
			7'd61:  c = 7'h37;
			7'd62:  c = 7'h38;
			7'd65:  c = 7'h2c;
			7'd66:  c = 7'h6b;
			7'd67:  c = 7'h69;
			7'd68:  c = 7'h6f;
			7'd69:  c = 7'h30;
			7'd70:  c = 7'h39;
			7'd73:  c = 7'h2e;
			7'd74:  c = 7'h2f;
			7'd75:  c = 7'h6c;
			7'd76:  c = 7'h3b;
			7'd77:  c = 7'h70;
			7'd78:  c = 7'h2d;
			7'd82:  c = 7'h27;
			7'd84:  c = 7'h5b;
			7'd85:  c = 7'h3d;
			7'd91:  c = 7'h5d;
			7'd93:  c = 7'h5c;
			7'd105: c = 7'h31;
			7'd107: c = 7'h34;
			7'd108: c = 7'h37;
			7'd112: c = 7'h30;
			7'd113: c = 7'h2e;
			7'd114: c = 7'h32;
			7'd115: c = 7'h35;
			7'd116: c = 7'h36;
			7'd117: c = 7'h38;
			7'd121: c = 7'h2b;
			7'd122: c = 7'h33;
			7'd123: c = 7'h2d;
			7'd124: c = 7'h2a;
			7'd125: c = 7'h39;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [CharW-1:0] apply_shift(input logic [CharW-1:0] c,
			input logic sh, input logic caps);
		logic [CharW-1:0] r;
		r = c;
		if (c inside {[7'h61:7'h7a]}) begin
			r = (sh ^ caps) ? c - 7'h20 : c;
		end else if (sh) begin
			case (c)
				7'h31: r = 7'h21;
				7'h32: r = 7'h40;
				7'h33: r = 7'h23;
				7'h34: r = 7'h24;
				7'h35: r = 7'h25;
				7'h36: r = 7'h5e;
				7'h37: r = 7'h26;
				7'h38: r = 7'h2a;
				7'h39: r = 7'h28;
				7'h30: r = 7'h29;
				7'h60: r = 7'h7e;
				7'h2d: r = 7'h5f;
				7'h3d: r = 7'h2b;
				7'h5b: r = 7'h7b;
				7'h5d: r = 7'h7d;
				7'h5c: r = 7'h7c;
				7'h3b: r = 7'h3a;
				7'h27: r = 7'h22;
				7'h2c: r = 7'h3c;
				7'h2e: r = 7'h3e;
				7'h2f: r = 7'h3f;
				default: r = c;
			endcase
		end
		return r;
	endfunction

	logic [CharW-1:0] base;
	logic             low_half;
	logic             numpad;

	assign low_half = ~code[CodeW-1];
	assign base     = low_half ? base_map(code[CharW-1:0]) : '0;
	assign numpad   = code inside {8'd105, 8'd107, 8'd108, 8'd112, 8'd113, 8'd114,
		8'd115, 8'd116, 8'd117, 8'd122, 8'd125};

	always_comb begin
		kind = EV_NONE;
		ch   = '0;
		case (code)
			8'd90, 8'd25: kind = EV_ENTER;
			8'd13:  kind = EV_TAB;
			8'd102: kind = EV_BKSP;
			8'd118: kind = EV_ESC;
			8'd134: kind = mods.ctrl ? EV_CLEFT  : EV_LEFT;
			8'd141: kind = mods.ctrl ? EV_CRIGHT : EV_RIGHT;
			8'd137: kind = mods.ctrl ? EV_CUP    : EV_UP;
			8'd138: kind = mods.ctrl ? EV_CDOWN  : EV_DOWN;
			8'd133: kind = EV_DEL;
			8'd128: begin
				kind = EV_CHAR;
				ch   = 7'h2f;
			end
			8'd135: kind = EV_HOME;
			8'd136: kind = EV_END;
			8'd139: kind = EV_PGUP;
			8'd140: kind = EV_PGDN;
			8'd6:   kind = EV_F2;
			8'd4:   kind = EV_F3;
			8'd3:   kind = EV_F5;
			8'd11:  kind = EV_F6;
			8'd10:  kind = EV_F8;
			8'd1:   kind = EV_F9;
			8'd9:   kind = EV_F10;
			8'd120: kind = EV_F11;
			8'd7:   kind = EV_F12;
			default: begin
				if (mods.ctrl && base == 7'h63) begin
					kind = EV_CLEAR;
				end else if (numpad && !mods.num) begin
					kind = EV_NONE;
				end else if (base != '0) begin
					kind = EV_CHAR;
					ch   = apply_shift(base, mods.shift, mods.caps);
				end
			end
		endcase
	end

endmodule

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kscd_pkg::*;

	// Scan codes that decode to fixed events (set 2, extended keys folded above 127)
	localparam logic [CodeW-1:0] KEY_F9       = 8'd1;
	localparam logic [CodeW-1:0] KEY_F5       = 8'd3;
	localparam logic [CodeW-1:0] KEY_F3       = 8'd4;
	localparam logic [CodeW-1:0] KEY_F2       = 8'd6;
	localparam logic [CodeW-1:0] KEY_F12      = 8'd7;
	localparam logic [CodeW-1:0] KEY_F10      = 8'd9;
	localparam logic [CodeW-1:0] KEY_F8       = 8'd10;
	localparam logic [CodeW-1:0] KEY_F6       = 8'd11;
	localparam logic [CodeW-1:0] KEY_TAB      = 8'd13;
	localparam logic [CodeW-1:0] KEY_KP_ENTER = 8'd25;
	localparam logic [CodeW-1:0] KEY_ENTER    = 8'd90;
	localparam logic [CodeW-1:0] KEY_BKSP     = 8'd102;
	localparam logic [CodeW-1:0] KEY_ESC      = 8'd118;
	localparam logic [CodeW-1:0] KEY_F11      = 8'd120;
	localparam logic [CodeW-1:0] KEY_KP_SLASH = 8'd128;
	localparam logic [CodeW-1:0] KEY_DEL      = 8'd133;
	localparam logic [CodeW-1:0] KEY_LEFT     = 8'd134;
	localparam logic [CodeW-1:0] KEY_HOME     = 8'd135;
	localparam logic [CodeW-1:0] KEY_END      = 8'd136;
	localparam logic [CodeW-1:0] KEY_UP       = 8'd137;
	localparam logic [CodeW-1:0] KEY_DOWN     = 8'd138;
	localparam logic [CodeW-1:0] KEY_PGUP     = 8'd139;
	localparam logic [CodeW-1:0] KEY_PGDN     = 8'd140;
	localparam logic [CodeW-1:0] KEY_RIGHT    = 8'd141;

	// keypad digit keys, muted while Num Lock is off
	localparam logic [CodeW-1:0] KP_1 = 8'd105, KP_4 = 8'd107, KP_7 = 8'd108;
	localparam logic [CodeW-1:0] KP_0 = 8'd112, KP_DOT = 8'd113, KP_2 = 8'd114;
	localparam logic [CodeW-1:0] KP_5 = 8'd115, KP_6 = 8'd116, KP_8 = 8'd117;
	localparam logic [CodeW-1:0] KP_3 = 8'd122, KP_9 = 8'd125;

	// plain keys used by the directed tests
	localparam logic [CodeW-1:0] KEY_NONE     = 8'd0;
	localparam logic [CodeW-1:0] KEY_A        = 8'd28;
	localparam logic [CodeW-1:0] KEY_C        = 8'd33;
	localparam logic [CodeW-1:0] KEY_1        = 8'd22;
	localparam logic [CodeW-1:0] KEY_UNMAPPED = 8'hFF;

	localparam logic [CodeW-1:0] KEY_CAPS   = TOGGLE_CODES[TGL_CAPS];
	localparam logic [CodeW-1:0] KEY_NUM    = TOGGLE_CODES[TGL_NUM];
	localparam logic [CodeW-1:0] KEY_INSERT = TOGGLE_CODES[TGL_INS];
	localparam logic [CodeW-1:0] KEY_SCROLL = TOGGLE_CODES[TGL_SCR];

	localparam logic [7:0] CH_BACKTICK = 8'h60;
	localparam logic [7:0] CH_SLASH    = 8'h2F;

	localparam int NUM_FIXED_KEYS = 25;
	localparam logic [CodeW-1:0] FIXED_KEYS [NUM_FIXED_KEYS] = '{
		KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN, KEY_ENTER, KEY_KP_ENTER, KEY_TAB,
		KEY_BKSP, KEY_ESC, KEY_DEL, KEY_KP_SLASH, KEY_HOME, KEY_END, KEY_PGUP,
		KEY_PGDN, KEY_F2, KEY_F3, KEY_F5, KEY_F6, KEY_F8, KEY_F9, KEY_F10,
		KEY_F11, KEY_F12, KEY_NONE
	};

	localparam int QUIET_LIMIT  = 2000; // cycles with no transaction before giving up
	localparam int DRAIN_CYCLES = 8;    // a report passes stage 1 and then the result register

	typedef struct {
		event_kind_t         kind;
		logic [CharW-1:0]    ch;
		logic                caps;
		logic                num;
		logic                ins;
		logic                scr;
	} key_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  keyboard_present = 1'b0;
	logic                  make_flag = 1'b0;
	logic                  break_flag = 1'b0;
	logic [CodeW-1:0]      scan_code = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KindW-1:0]      event_kind;
	logic [CharW-1:0]      character;
	logic                  caps_lock_on;
	logic                  num_lock_on;
	logic                  insert_on;
	logic                  scroll_lock_on;
	logic                  cfg_write_en = 1'b0;
	logic [0:0]            cfg_index = '0;
	logic [CfgW-1:0]       cfg_data = '0;

	keyboard_scancode_decoder u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.keyboard_present (keyboard_present),
		.make_flag        (make_flag),
		.break_flag       (break_flag),
		.scan_code        (scan_code),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_kind       (event_kind),
		.character        (character),
		.caps_lock_on     (caps_lock_on),
		.num_lock_on      (num_lock_on),
		.insert_on        (insert_on),
		.scroll_lock_on   (scroll_lock_on),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Keyboard state as the block should see it, updated once per accepted report
	logic [CfgW-1:0]   delay_reg     = RESET_REPEAT_DELAY;
	logic [CfgW-1:0]   interval_reg  = RESET_REPEAT_INTERVAL;
	logic [CodeW-1:0]  held_code     = '0;
	logic [7:0]        countdown     = '0;
	logic              ctrl_pressed  = 1'b0;
	logic              shift_pressed = 1'b0;
	logic [NumTgl-1:0] lock_latch    = '0;
	logic [NumTgl-1:0] lock_state    = '0;

	key_event_t  expected_events[$];
	int          mismatch_count = 0;
	int          reports_sent   = 0;
	int          quiet_cycles   = 0;
	int unsigned send_idle_pct  = 31;
	int unsigned recv_stall_pct = 62;

	// US layout, unshifted; codes without a character give 0
	function automatic logic [7:0] base_char(input logic [CodeW-1:0] code);
		case (code)
			8'd14: return CH_BACKTICK;
			8'd21: return "q";  8'd22: return "1";  8'd26: return "z";  8'd27: return "s";
			8'd28: return "a";  8'd29: return "w";  8'd30: return "2";  8'd33: return "c";
			8'd34: return "x";  8'd35: return "d";  8'd36: return "e";  8'd37: return "4";
			8'd38: return "3";  8'd41: return " ";  8'd42: return "v";  8'd43: return "f";
			8'd44: return "t";  8'd45: return "r";  8'd46: return "5";  8'd49: return "n";
			8'd50: return "b";  8'd51: return "h";  8'd52: return "g";  8'd53: return "y";
			8'd54: return "6";  8'd58: return "m";  8'd59: return "j";  8'd60: return "u";
			8'd61: return "7";  8'd62: return "8";  8'd65: return ",";  8'd66: return "k";
			8'd67: return "i";  8'd68: return "o";  8'd69: return "0";  8'd70: return "9";
			8'd73: return ".";  8'd74: return "/";  8'd75: return "l";  8'd76: return ";";
			8'd77: return "p";  8'd78: return "-";  8'd82: return "'";  8'd84: return "[";
			8'd85: return "=";  8'd91: return "]";  8'd93: return "\\";
			KP_1: return "1";   KP_4: return "4";   KP_7: return "7";   KP_0: return "0";
			KP_DOT: return "."; KP_2: return "2";   KP_5: return "5";   KP_6: return "6";
			KP_8: return "8";   KP_3: return "3";   KP_9: return "9";
			8'd121: return "+"; 8'd123: return "-"; 8'd124: return "*";
			default: return 8'h00;
		endcase
	endfunction

	// letters follow shift xor caps; everything else follows shift only
	function automatic logic [7:0] shifted_char(input logic [7:0] c, input logic sh, caps);
		if (c >= "a" && c <= "z")
			return (sh ^ caps) ? c - 8'd32 : c;
		if (!sh)
			return c;
		case (c)
			"1": return "!";  "2": return "@";  "3": return "#";  "4": return "$";
			"5": return "%";  "6": return "^";  "7": return "&";  "8": return "*";
			"9": return "(";  "0": return ")";  "-": return "_";  "=": return "+";
			"[": return "{";  "]": return "}";  ";": return ":";  "'": return "\"";
			",": return "<";  ".": return ">";  "/": return "?";  "\\": return "|";
			CH_BACKTICK: return "~";
			default: return c;
		endcase
	endfunction

	function automatic logic is_keypad_digit(input logic [CodeW-1:0] code);
		case (code)
			KP_1, KP_4, KP_7, KP_0, KP_DOT, KP_2, KP_5, KP_6, KP_8, KP_3, KP_9: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic event_kind_t lookup_event(input logic [CodeW-1:0] code,
			output logic [CharW-1:0] ch);
		logic [7:0] base;
		logic [7:0] c8;
		base = base_char(code);
		ch = '0;
		case (code)
			KEY_ENTER, KEY_KP_ENTER: return EV_ENTER;
			KEY_TAB:  return EV_TAB;
			KEY_BKSP: return EV_BKSP;
			KEY_ESC:  return EV_ESC;
			KEY_LEFT: begin
				if (ctrl_pressed) return EV_CLEFT;
				return EV_LEFT;
			end
			KEY_RIGHT: begin
				if (ctrl_pressed) return EV_CRIGHT;
				return EV_RIGHT;
			end
			KEY_UP: begin
				if (ctrl_pressed) return EV_CUP;
				return EV_UP;
			end
			KEY_DOWN: begin
				if (ctrl_pressed) return EV_CDOWN;
				return EV_DOWN;
			end
			KEY_DEL: return EV_DEL;
			KEY_KP_SLASH: begin
				ch = CH_SLASH[CharW-1:0];
				return EV_CHAR;
			end
			KEY_HOME: return EV_HOME;
			KEY_END:  return EV_END;
			KEY_PGUP: return EV_PGUP;
			KEY_PGDN: return EV_PGDN;
			KEY_F2:   return EV_F2;
			KEY_F3:   return EV_F3;
			KEY_F5:   return EV_F5;
			KEY_F6:   return EV_F6;
			KEY_F8:   return EV_F8;
			KEY_F9:   return EV_F9;
			KEY_F10:  return EV_F10;
			KEY_F11:  return EV_F11;
			KEY_F12:  return EV_F12;
			default: ;
		endcase
		// Ctrl-C wins over the character table
		if (ctrl_pressed && base == "c")
			return EV_CLEAR;
		if (is_keypad_digit(code) && !lock_state[TGL_NUM])
			return EV_NONE;
		if (base != 8'h00) begin
			c8 = shifted_char(base, shift_pressed, lock_state[TGL_CAPS]);
			ch = c8[CharW-1:0];
			return EV_CHAR;
		end
		return EV_NONE;
	endfunction

	// Advances the keyboard state by one report and returns the event it should give
	function automatic key_event_t decode_keystroke(input logic present, mk, br,
			input logic [CodeW-1:0] code);
		key_event_t ev;
		logic [CharW-1:0] ch;
		logic fire;
		ev.kind = EV_NONE;
		ch = '0;
		fire = 1'b0;
		if (!present) begin
			// lost keyboard: drop the held key and Ctrl, keep everything else
			held_code = '0;
			ctrl_pressed = 1'b0;
		end else begin
			// make is applied before break when both are set
			if (code == CODE_LCTRL) begin
				if (mk) ctrl_pressed = 1'b1;
				if (br) ctrl_pressed = 1'b0;
			end
			if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
				if (mk) shift_pressed = 1'b1;
				if (br) shift_pressed = 1'b0;
			end
			for (int t = 0; t < NumTgl; t++) begin
				if (code == TOGGLE_CODES[t]) begin
					if (mk && !lock_latch[t]) begin
						lock_state[t] = ~lock_state[t];
						lock_latch[t] = 1'b1;
					end
					if (br) lock_latch[t] = 1'b0;
				end
			end
			if (!mk || code == KEY_NONE) begin
				held_code = '0;
			end else begin
				if (code != held_code) begin
					held_code = code;
					countdown = delay_reg;
					fire = 1'b1;
				end else if (countdown <= 8'd1) begin
					countdown = interval_reg;
					fire = 1'b1;
				end else begin
					countdown = countdown - 8'd1;
				end
				if (fire)
					ev.kind = lookup_event(code, ch);
			end
		end
		ev.ch   = ch;
		ev.caps = lock_state[TGL_CAPS];
		ev.num  = lock_state[TGL_NUM];
		ev.ins  = lock_state[TGL_INS];
		ev.scr  = lock_state[TGL_SCR];
		return ev;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// One input transaction. Called right after a rising edge; returns at the
	// edge that accepted the report, with its expected event queued.
	task automatic send_report(input logic present, mk, br, input logic [CodeW-1:0] code);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		keyboard_present <= present;
		make_flag        <= mk;
		break_flag       <= br;
		scan_code        <= code;
		do
			@(posedge clk);
		while (in_stall);
		expected_events.push_back(decode_keystroke(present, mk, br, code));
		reports_sent++;
	endtask

	// Drop valid and let every outstanding transaction come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [CfgW-1:0] value);
		wait_idle();
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			CFG_REPEAT_DELAY:    delay_reg = value;
			CFG_REPEAT_INTERVAL: interval_reg = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic int frames_of(input logic [CfgW-1:0] v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	// Reset values of the repeat registers: first repeat on frame 31, then every 4
	task automatic test_reset_defaults();
		repeat (40) send_report(1'b1, 1'b1, 1'b0, KEY_A);
		send_report(1'b1, 1'b0, 1'b1, KEY_A);
	endtask

	// Every fixed event, the Ctrl variants of the arrows, and Ctrl-C as clear
	task automatic test_decode_keys();
		send_report(1'b1, 1'b1, 1'b0, CODE_LCTRL);
		send_report(1'b1, 1'b1, 1'b0, KEY_LEFT);
		send_report(1'b1, 1'b1, 1'b0, KEY_RIGHT);
		send_report(1'b1, 1'b1, 1'b0, KEY_UP);
		send_report(1'b1, 1'b1, 1'b0, KEY_DOWN);
		send_report(1'b1, 1'b1, 1'b0, KEY_C);
		send_report(1'b1, 1'b0, 1'b1, CODE_LCTRL);
		for (int i = 0; i < NUM_FIXED_KEYS; i++)
			send_report(1'b1, 1'b1, 1'b0, FIXED_KEYS[i]);
	endtask

	task automatic test_special_cases();
		// missing keyboard also forgets a held Ctrl
		send_report(1'b1, 1'b1, 1'b0, CODE_LCTRL);
		send_report(1'b0, 1'b1, 1'b1, KEY_UNMAPPED);
		send_report(1'b1, 1'b1, 1'b0, KEY_LEFT);
		// shift pressed and released in the same report ends up released
		send_report(1'b1, 1'b1, 1'b1, CODE_LSHIFT);
		send_report(1'b1, 1'b1, 1'b0, KEY_A);
		send_report(1'b1, 1'b1, 1'b0, CODE_RSHIFT);
		send_report(1'b1, 1'b1, 1'b0, KEY_1);
		send_report(1'b1, 1'b0, 1'b1, CODE_RSHIFT);
		// caps flips once per press, however long it is held
		send_report(1'b1, 1'b1, 1'b0, KEY_CAPS);
		send_report(1'b1, 1'b1, 1'b0, KEY_CAPS);
		send_report(1'b1, 1'b0, 1'b1, KEY_CAPS);
		send_report(1'b1, 1'b1, 1'b0, KEY_A);
		send_report(1'b1, 1'b1, 1'b1, KEY_CAPS);
		// no make, then a make with code zero
		send_report(1'b1, 1'b0, 1'b0, KEY_A);
		send_report(1'b1, 1'b1, 1'b0, KEY_NONE);
		send_report(1'b1, 1'b1, 1'b0, KEY_UNMAPPED);
		// keypad digit muted until Num Lock goes on
		send_report(1'b1, 1'b1, 1'b0, KP_7);
		send_report(1'b1, 1'b1, 1'b1, KEY_NUM);
		send_report(1'b1, 1'b1, 1'b0, KP_7);
		send_report(1'b1, 1'b1, 1'b1, KEY_INSERT);
		send_report(1'b1, 1'b1, 1'b1, KEY_SCROLL);
	endtask

	// Largest delay and interval: one key held through its first two repeats
	task automatic test_repeat_extremes();
		write_register(CFG_REPEAT_DELAY, 8'd255);
		write_register(CFG_REPEAT_INTERVAL, 8'd255);
		repeat (2 * 255 + 2) send_report(1'b1, 1'b1, 1'b0, KEY_C);
		send_report(1'b1, 1'b0, 1'b1, KEY_C);
	endtask

	// Mostly realistic typing (held keys, modifiers, lock keys) with some junk
	task automatic test_random_typing(input int unsigned sender_pct, receiver_pct,
			input logic [CfgW-1:0] delay_val, interval_val, input int n_items);
		int stop_at;
		int pick;
		int span;
		logic mk;
		logic br;
		logic [CodeW-1:0] code;
		write_register(CFG_REPEAT_DELAY, delay_val);
		write_register(CFG_REPEAT_INTERVAL, interval_val);
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
		span = frames_of(delay_val) + 3 * frames_of(interval_val) + 1;
		stop_at = reports_sent + n_items;
		while (reports_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// junk report, any field combination
				send_report(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else if (pick < 14) begin
				send_report(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
			end else if (pick < 24) begin
				case ($urandom_range(0, 2))
					0: code = CODE_LCTRL;
					1: code = CODE_LSHIFT;
					default: code = CODE_RSHIFT;
				endcase
				pick = $urandom_range(0, 9);
				mk = (pick < 5) || (pick == 9);
				br = (pick >= 5);
				send_report(1'b1, mk, br, code);
			end else if (pick < 31) begin
				code = TOGGLE_CODES[$urandom_range(0, NumTgl - 1)];
				if ($urandom_range(0, 9) == 0) begin
					send_report(1'b1, 1'b1, 1'b1, code);
				end else begin
					repeat ($urandom_range(1, 3)) send_report(1'b1, 1'b1, 1'b0, code);
					if ($urandom_range(0, 6) != 0)
						send_report(1'b1, 1'b0, 1'b1, code);
				end
			end else begin
				if ($urandom_range(0, 3) == 0)
					code = 8'($urandom_range(0, 255));
				else
					code = 8'($urandom_range(1, 141));
				repeat ($urandom_range(1, span)) send_report(1'b1, 1'b1, 1'b0, code);
				if ($urandom_range(0, 4) != 0)
					send_report(1'b1, 1'b0, 1'b1, code);
			end
		end
	endtask

	// Receiver side: random stall, sampled by the DUT at the next edge
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// Every output transaction is checked against the oldest expected event
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected result, event_kind %0d", event_kind));
			end else begin
				want = expected_events.pop_front();
				if (event_kind !== want.kind)
					report_mismatch($sformatf("event_kind %0d, want %0d (%s)",
						event_kind, want.kind, want.kind.name()));
				if (character !== want.ch)
					report_mismatch($sformatf("character 0x%02h, want 0x%02h",
						character, want.ch));
				if (caps_lock_on !== want.caps)
					report_mismatch($sformatf("caps_lock_on %b, want %b", caps_lock_on, want.caps));
				if (num_lock_on !== want.num)
					report_mismatch($sformatf("num_lock_on %b, want %b", num_lock_on, want.num));
				if (insert_on !== want.ins)
					report_mismatch($sformatf("insert_on %b, want %b", insert_on, want.ins));
				if (scroll_lock_on !== want.scr)
					report_mismatch($sformatf("scroll_lock_on %b, want %b",
						scroll_lock_on, want.scr));
			end
		end
	end

	// Watchdog: any transaction on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
				QUIET_LIMIT, expected_events.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles 31%, receiver stalls 62%
		test_reset_defaults();
		test_decode_keys();
		test_special_cases();
		test_repeat_extremes();
		test_random_typing(31, 62, 8'd0, 8'd1, 50);
		// roles swapped
		test_random_typing(62, 31, 8'd6, 8'd3, 50);
		// full rate both ways
		test_random_typing(0, 0, 8'd4, 8'd0, 50);

		wait_idle();
		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d results never came", expected_events.size()));
		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
